[rtl/air_pkg.sv]
// ----------------------------------------------------------------------------
// Audio interleave reformatter package
// Shared payload types, register indexes, mode and status codes and default
// block geometry for the audio interleave reformatter.
// ----------------------------------------------------------------------------
`default_nettype none

package air_pkg;

    // Default block geometry.
    localparam int FRAMES_DEF       = 16;
    localparam int IN_CHANNELS_DEF  = 2;
    localparam int OUT_CHANNELS_DEF = 2;

    // Sample word width.
    localparam int SAMPLE_W = 32;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CONVERSION_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_FILE      = 1'd1;

    // Conversion mode codes; every other code is invalid.
    localparam logic [2:0] MODE_CODE_1 = 3'd1;
    localparam logic [2:0] MODE_CODE_2 = 3'd2;
    localparam logic [2:0] MODE_CODE_3 = 3'd3;
    localparam logic [2:0] MODE_CODE_4 = 3'd4;

    // Register reset values.
    localparam logic [2:0] CONVERSION_MODE_RST = MODE_CODE_1;
    localparam logic       BLOCK_FILE_RST      = 1'b1;

    // Command codes.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_MODE   = 2'd1;
    localparam logic [1:0] STATUS_NOT_LOADED = 2'd2;

    // Input item.
    typedef struct packed {
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] in_sample;
    } t_air_in;

    // Result item.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_sample;
        logic                       last_of_block;
        logic [1:0]                 status;
    } t_air_out;

endpackage

`default_nettype wire

[rtl/audio_interleave_reformatter.sv]
// ----------------------------------------------------------------------------
// Audio interleave reformatter
// Loads one block of FRAMES x IN_CHANNELS samples by push commands and
// returns FRAMES x OUT_CHANNELS samples by pull commands, either in stored
// order or transposed between interleaved and planar layout.
//
//   Channel   Ports                             Transfer
//   command   i_start, o_busy, i_item           i_start high while o_busy low
//   result    o_valid, o_result                 o_valid high, one cycle only
//   config    i_cfg_we, i_cfg_idx, i_cfg_data   i_cfg_we high
//
// One command is taken every clock cycle; o_busy stays low.
// A pull gives its result in the cycle after it is taken, from the
// registered read port of the sample RAM. A push gives no result.
// Reset is synchronous and active low; it clears the counters and the
// registers but not the sample RAM, whose entries are always written
// before they are read. The receiver cannot stall the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_interleave_reformatter
    import air_pkg::*;
#(
    parameter int FRAMES       = FRAMES_DEF,
    parameter int IN_CHANNELS  = IN_CHANNELS_DEF,
    parameter int OUT_CHANNELS = OUT_CHANNELS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire t_air_in               i_item,
    output logic                       o_valid,
    output t_air_out                   o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int BLOCK_LEN = FRAMES * IN_CHANNELS;
    localparam int OUT_LEN   = FRAMES * OUT_CHANNELS;
    localparam int AW        = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
    localparam int WCW       = $clog2(BLOCK_LEN + 1);
    localparam int KW        = (OUT_LEN > 1) ? $clog2(OUT_LEN) : 1;
    localparam int FW        = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW        = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;

    // Configuration registers.
    logic [2:0]     r_conversion_mode;
    logic           r_block_file;

    // Block counters: load count, output index, and its frame and channel.
    logic [WCW-1:0] r_write_count, n_write_count;
    logic [KW-1:0]  r_read_index,  n_read_index;
    logic [FW-1:0]  r_frame,       n_frame;
    logic [CW-1:0]  r_chan,        n_chan;

    // Result registers.
    logic           r_valid;
    logic           r_last;
    logic [1:0]     r_status;

    logic                accept;
    logic                push;
    logic                pull;
    logic                full;
    logic                mode_ok;
    logic                transpose;
    logic                last_idx;
    logic                advance;
    logic [AW-1:0]       raddr;
    logic [SAMPLE_W-1:0] rdata;

    assign o_busy = 1'b0;

    // Command decode and block status.
    assign accept  = i_start && !o_busy;
    assign push    = accept && (i_item.cmd == CMD_PUSH);
    assign pull    = accept && (i_item.cmd == CMD_PULL);
    assign full    = (r_write_count == WCW'(BLOCK_LEN));
    assign mode_ok = (r_conversion_mode == MODE_CODE_1) ||
                     (r_conversion_mode == MODE_CODE_2) ||
                     (r_conversion_mode == MODE_CODE_3) ||
                     (r_conversion_mode == MODE_CODE_4);
    assign last_idx = (r_read_index == KW'(OUT_LEN - 1));
    assign advance  = pull && full && mode_ok;

    // Modes 1 and 4 transpose an interleaved file, modes 2 and 3 a block file.
    always_comb begin
        if ((r_conversion_mode == MODE_CODE_1) || (r_conversion_mode == MODE_CODE_4)) begin
            transpose = !r_block_file;
        end else begin
            transpose = r_block_file;
        end
    end

    // Source address: stored order is channel-major, transpose is frame-major.
    always_comb begin
        if (transpose) begin
            raddr = AW'(32'(r_frame) * IN_CHANNELS + 32'(r_chan));
        end else begin
            raddr = AW'(32'(r_chan) * FRAMES + 32'(r_frame));
        end
    end

    // Next values of the block counters.
    always_comb begin
        n_write_count = r_write_count;
        n_read_index  = r_read_index;
        n_frame       = r_frame;
        n_chan        = r_chan;
        if (push && !full) begin
            n_write_count = r_write_count + WCW'(1);
        end
        if (advance) begin
            if (last_idx) begin
                n_write_count = '0;
                n_read_index  = '0;
                n_frame       = '0;
                n_chan        = '0;
            end else begin
                n_read_index = r_read_index + KW'(1);
                if (r_frame == FW'(FRAMES - 1)) begin
                    n_frame = '0;
                    if (r_chan == CW'(IN_CHANNELS - 1)) begin
                        n_chan = '0;
                    end else begin
                        n_chan = r_chan + CW'(1);
                    end
                end else begin
                    n_frame = r_frame + FW'(1);
                end
            end
        end
    end

    // Sample store.
    air_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BLOCK_LEN)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (push && !full),
        .i_waddr (r_write_count[AW-1:0]),
        .i_wdata (i_item.in_sample),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Configuration, counters and result control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conversion_mode <= CONVERSION_MODE_RST;
            r_block_file      <= BLOCK_FILE_RST;
            r_write_count     <= '0;
            r_read_index      <= '0;
            r_frame           <= '0;
            r_chan            <= '0;
            r_valid           <= 1'b0;
            r_last            <= 1'b0;
            r_status          <= STATUS_OK;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CONVERSION_MODE: r_conversion_mode <= i_cfg_data[2:0];
                    CFG_BLOCK_FILE:      r_block_file      <= i_cfg_data[0];
                endcase
            end
            r_write_count <= n_write_count;
            r_read_index  <= n_read_index;
            r_frame       <= n_frame;
            r_chan        <= n_chan;
            r_valid       <= pull;
            r_last        <= advance && last_idx;
            if (!full) begin
                r_status <= STATUS_NOT_LOADED;
            end else if (!mode_ok) begin
                r_status <= STATUS_BAD_MODE;
            end else begin
                r_status <= STATUS_OK;
            end
        end
    end

    // Result port; error results carry a zero sample.
    assign o_valid                = r_valid;
    assign o_result.last_of_block = r_last;
    assign o_result.status        = r_status;
    assign o_result.out_sample    = (r_status == STATUS_OK) ? $signed(rdata) : '0;

endmodule

`default_nettype wire

[rtl/air_ram.sv]
// ----------------------------------------------------------------------------
// Generic sample RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module air_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/air_checker.sv]
// ----------------------------------------------------------------------------
// Audio interleave reformatter checker
// Port-level assertions on command, result and block sequencing, bound to
// the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module air_checker
    import air_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_start,
    input wire logic                  o_busy,
    input wire t_air_in               i_item,
    input wire logic                  o_valid,
    input wire t_air_out              o_result
);

    logic pull_xfer;

    assign pull_xfer = i_start && !o_busy && (i_item.cmd == CMD_PULL);

    // Every pull transfer gives a result in the next cycle.
    a_pull_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pull_xfer |=> o_valid)
        else $error("pull transfer without result");

    // No result appears without a pull transfer in the previous cycle.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_rst_n)) |-> $past(pull_xfer))
        else $error("result without pull transfer");

    // Error results carry a zero sample and no end-of-block mark.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status != STATUS_OK)) |->
            ((o_result.out_sample == '0) && !o_result.last_of_block))
        else $error("error result with data");

    // A pull right after the end of a block finds the block empty.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last_of_block && pull_xfer) |=>
            (o_valid && (o_result.status == STATUS_NOT_LOADED)))
        else $error("block not restarted after last sample");

endmodule

bind audio_interleave_reformatter air_checker u_air_checker (.*);

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio interleave reformatter testbench
// Loads sample blocks with push commands and reads them back with pull
// commands under every conversion mode and file layout. A shadow copy of the
// sample store and counters predicts each pull result, and every result is
// checked field by field against the oldest prediction. Covered: pulls before
// a block is full, invalid modes, pushes into a full block, block wrap-around,
// register changes inside a block, and random idle gaps on the sender.
// ----------------------------------------------------------------------------
module tb;

    import air_pkg::*;

    localparam int BLOCK_LEN     = FRAMES_DEF * IN_CHANNELS_DEF;
    localparam int OUT_LEN       = FRAMES_DEF * OUT_CHANNELS_DEF;
    localparam int RANDOM_ITEMS  = 360;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 10;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    t_air_in               i_item;
    logic                  o_valid;
    t_air_out              o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Shadow state of the reformatter.
    logic [SAMPLE_W-1:0] shadow_store [BLOCK_LEN];
    int unsigned         shadow_wr;
    int unsigned         shadow_rd;
    logic [2:0]          shadow_mode;
    logic                shadow_blk;

    t_air_out expected_outputs [$];
    int       mismatches;
    int       items_sent;
    int       burst_left;
    int       cycle_count;
    logic     checking_on;

    audio_interleave_reformatter #(
        .FRAMES       (FRAMES_DEF),
        .IN_CHANNELS  (IN_CHANNELS_DEF),
        .OUT_CHANNELS (OUT_CHANNELS_DEF)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic mode_valid(input logic [2:0] mode);
        return (mode >= MODE_CODE_1) && (mode <= MODE_CODE_4);
    endfunction

    // Update the shadow state for one accepted command and queue the
    // result that a pull produces.
    task automatic predict_command(input t_air_in item);
        t_air_out    res;
        int unsigned k;
        int unsigned m;
        int unsigned src;
        logic        xpose;
        if (item.cmd == CMD_PUSH) begin
            if (shadow_wr < BLOCK_LEN) begin
                shadow_store[shadow_wr] = item.in_sample;
                shadow_wr++;
            end
        end else begin
            res = '0;
            if (shadow_wr < BLOCK_LEN) begin
                res.status = STATUS_NOT_LOADED;
            end else if (!mode_valid(shadow_mode)) begin
                res.status = STATUS_BAD_MODE;
            end else begin
                k = (shadow_rd >= OUT_LEN) ? 0 : shadow_rd;
                if (shadow_mode == MODE_CODE_1 || shadow_mode == MODE_CODE_4) begin
                    xpose = (shadow_blk == 1'b0);
                end else begin
                    xpose = (shadow_blk == 1'b1);
                end
                m   = k % BLOCK_LEN;
                src = xpose ? (m % FRAMES_DEF) * IN_CHANNELS_DEF + m / FRAMES_DEF : m;
                if (src >= BLOCK_LEN) src = 0;
                res.out_sample    = shadow_store[src];
                res.last_of_block = (k + 1 == OUT_LEN);
                res.status        = STATUS_OK;
                if (res.last_of_block) begin
                    shadow_rd = 0;
                    shadow_wr = 0;
                end else begin
                    shadow_rd = k + 1;
                end
            end
            expected_outputs.push_back(res);
        end
    endtask

    // Idle gap before the next transfer, with stretches of back-to-back
    // commands mixed in.
    function automatic int draw_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    // Send one command and wait for its transfer.
    task automatic send_item(input logic cmd, input logic [SAMPLE_W-1:0] smp);
        int      gap;
        t_air_in item;
        gap            = draw_gap();
        item.cmd       = cmd;
        item.in_sample = smp;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= item;
        do @(posedge i_clk); while (o_busy);
        predict_command(item);
        items_sent++;
    endtask

    // Stop sending and wait until every pending result has arrived.
    task automatic drain();
        i_start <= 1'b0;
        while (expected_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write, only with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == CFG_CONVERSION_MODE) begin
            shadow_mode = data[2:0];
        end else begin
            shadow_blk = data[0];
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input t_air_out exp_r,
                                   input t_air_out got_r);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t %s: expected sample %h last %b status %0d, got sample %h last %b status %0d",
                     $realtime, what, exp_r.out_sample, exp_r.last_of_block, exp_r.status,
                     got_r.out_sample, got_r.last_of_block, got_r.status);
        end
    endtask

    // Compare each result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_air_out exp_r;
        if (checking_on && o_valid) begin
            if (expected_outputs.size() == 0) begin
                report_mismatch("unexpected result", '0, o_result);
            end else begin
                exp_r = expected_outputs.pop_front();
                if (o_result.out_sample !== exp_r.out_sample ||
                    o_result.last_of_block !== exp_r.last_of_block ||
                    o_result.status !== exp_r.status) begin
                    report_mismatch("result mismatch", exp_r, o_result);
                end
            end
        end
    end

    // Pulls on an empty and on a partly loaded block, with extreme samples.
    task automatic test_not_loaded();
        send_item(CMD_PULL, '0);
        send_item(CMD_PUSH, 32'h8000_0000);
        send_item(CMD_PUSH, 32'h7FFF_FFFF);
        send_item(CMD_PUSH, 32'h0000_0000);
        send_item(CMD_PUSH, 32'hFFFF_FFFF);
        send_item(CMD_PULL, 32'hFFFF_FFFF);
    endtask

    // Fill the block, then push into the full block.
    task automatic test_full_block_push();
        while (shadow_wr < BLOCK_LEN) send_item(CMD_PUSH, $urandom);
        send_item(CMD_PUSH, 32'h5A5A_A5A5);
        send_item(CMD_PUSH, $urandom);
    endtask

    // Every invalid conversion mode on a full block.
    task automatic test_bad_mode();
        for (int code = 0; code < 8; code++) begin
            if (!mode_valid(code[2:0])) begin
                write_reg(CFG_CONVERSION_MODE, code[2:0]);
                send_item(CMD_PULL, $urandom);
            end
        end
    endtask

    // Each valid mode under both layouts reads a slice of the same block;
    // the final pull ends the block.
    task automatic test_mode_layouts();
        for (int blk = 0; blk < 2; blk++) begin
            write_reg(CFG_BLOCK_FILE, CFG_DATA_W'(blk));
            for (int code = MODE_CODE_1; code <= MODE_CODE_4; code++) begin
                write_reg(CFG_CONVERSION_MODE, code[2:0]);
                repeat (OUT_LEN / 8) send_item(CMD_PULL, $urandom);
            end
        end
    endtask

    // After the end of a block a pull finds it empty again.
    task automatic test_block_restart();
        send_item(CMD_PULL, $urandom);
    endtask

    // Random conversion mode, mostly valid.
    function automatic logic [2:0] draw_mode();
        if ($urandom_range(0, 5) == 0) begin
            return ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(5, 7));
        end
        return 3'($urandom_range(MODE_CODE_1, MODE_CODE_4));
    endfunction

    // Random register write; block_file data carries random upper bits.
    task automatic write_random_reg();
        if ($urandom_range(0, 1) == 0) begin
            write_reg(CFG_CONVERSION_MODE, draw_mode());
        end else begin
            write_reg(CFG_BLOCK_FILE, CFG_DATA_W'($urandom));
        end
    endtask

    // Whole blocks with random content, some noise and register changes.
    task automatic test_random_blocks();
        int stop_at;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 2) == 0) write_random_reg();
            // Load phase, with the odd early pull.
            while (shadow_wr < BLOCK_LEN) begin
                if ($urandom_range(0, 11) == 0) send_item(CMD_PULL, $urandom);
                else send_item(CMD_PUSH, $urandom);
            end
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) send_item(CMD_PUSH, $urandom);
            end
            // Read phase until the block ends.
            while (shadow_wr != 0) begin
                if (!mode_valid(shadow_mode)) begin
                    send_item(CMD_PULL, $urandom);
                    write_reg(CFG_CONVERSION_MODE,
                              3'($urandom_range(MODE_CODE_1, MODE_CODE_4)));
                end else if ($urandom_range(0, 15) == 0) begin
                    write_random_reg();
                end else if ($urandom_range(0, 19) == 0) begin
                    send_item(CMD_PUSH, $urandom);
                end else begin
                    send_item(CMD_PULL, $urandom);
                end
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_item      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_data  <= '0;
        cycle_count = 0;
        mismatches  = 0;
        items_sent  = 0;
        burst_left  = 0;
        checking_on = 1'b0;
        shadow_wr   = 0;
        shadow_rd   = 0;
        shadow_mode = CONVERSION_MODE_RST;
        shadow_blk  = BLOCK_FILE_RST;
        foreach (shadow_store[i]) shadow_store[i] = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n     <= 1'b1;
        checking_on = 1'b1;

        test_not_loaded();
        test_full_block_push();
        test_bad_mode();
        test_mode_layouts();
        test_block_restart();
        test_random_blocks();

        drain();
        if (mismatches == 0 && expected_outputs.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/air_pkg.sv
rtl/air_ram.sv
rtl/audio_interleave_reformatter.sv
rtl/air_checker.sv
bench/tb.sv
